### rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// clocked assertions with asynchronous active-low reset disable
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, off while reset is held
`define APSC_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define APSC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	`APSC_ASSERT(label, clk, rst_n, (ante) |-> (cons))

`endif

### rtl/core/apsc_pkg.sv
// ---------------------------------------------------------------------------
// apsc_pkg
// shared constants, types and helpers of the substitution counter
// ---------------------------------------------------------------------------
`default_nettype none

package apsc_pkg;

	localparam int COUNT_BITS = 16;
	localparam int FIELD_BITS = 16;
	localparam int BASE_BITS  = 8;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	localparam logic [BASE_BITS-1:0] CH_A   = 8'h41;
	localparam logic [BASE_BITS-1:0] CH_C   = 8'h43;
	localparam logic [BASE_BITS-1:0] CH_G   = 8'h47;
	localparam logic [BASE_BITS-1:0] CH_T   = 8'h54;
	localparam logic [BASE_BITS-1:0] CH_N   = 8'h4E;
	localparam logic [BASE_BITS-1:0] CH_GAP = 8'h2D;

	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [FIELD_BITS-1:0] field_t;

	// one-hot-or-zero column class
	typedef struct packed {
		logic transition;
		logic transversion;
		logic match;
		logic missing;
	} class_t;

	function automatic count_t sat_bump(input count_t v, input logic inc);
		count_t r;
		r = v;
		if (inc && v != COUNT_MAX) begin
			r = v + count_t'(1);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/core/apsc_if.sv
// ---------------------------------------------------------------------------
// apsc channel interfaces
// column word in, count result word out, valid/ready handshake
// ---------------------------------------------------------------------------
`default_nettype none

interface apsc_col_if import apsc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [BASE_BITS-1:0] base_first;
	logic [BASE_BITS-1:0] base_second;
	logic                 last_column;

	modport source (output valid, base_first, base_second, last_column, input ready);
	modport sink   (input valid, base_first, base_second, last_column, output ready);
endinterface

interface apsc_res_if import apsc_pkg::*; ();
	logic   valid;
	logic   ready;
	field_t transition_count;
	field_t transversion_count;
	field_t match_count;
	field_t missing_count;
	field_t column_total;

	modport source (output valid, transition_count, transversion_count, match_count,
		missing_count, column_total, input ready);
	modport sink   (input valid, transition_count, transversion_count, match_count,
		missing_count, column_total, output ready);
endinterface

`default_nettype wire

### rtl/core/apsc_classify.sv
// ---------------------------------------------------------------------------
// apsc_classify
// sorts one aligned column into transition, transversion, match or missing
// ---------------------------------------------------------------------------
`default_nettype none

module apsc_classify import apsc_pkg::*; (
	input  wire logic [BASE_BITS-1:0] base_first,
	input  wire logic [BASE_BITS-1:0] base_second,
	output class_t                    hit
);

	logic pur_a, pur_b, pyr_a, pyr_b, nuc_a, nuc_b, same;

	always_comb begin
		pur_a = (base_first == CH_A) || (base_first == CH_G);
		pur_b = (base_second == CH_A) || (base_second == CH_G);
		pyr_a = (base_first == CH_C) || (base_first == CH_T);
		pyr_b = (base_second == CH_C) || (base_second == CH_T);
		nuc_a = pur_a || pyr_a;
		nuc_b = pur_b || pyr_b;
		same  = (base_first == base_second);

		hit.match        = nuc_a && nuc_b && same;
		hit.transition   = nuc_a && nuc_b && !same && ((pur_a && pur_b) || (pyr_a && pyr_b));
		hit.transversion = nuc_a && nuc_b && ((pur_a && pyr_b) || (pyr_a && pur_b));
		// case-sensitive: only upper-case N or gap on both sides
		hit.missing      = same && ((base_first == CH_N) || (base_first == CH_GAP));
	end

endmodule

`default_nettype wire

### rtl/core/apsc_accum.sv
// ---------------------------------------------------------------------------
// apsc_accum
// saturating running counters and the registered result word
// ---------------------------------------------------------------------------
`default_nettype none

module apsc_accum import apsc_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   take,
	input  wire logic   last_column,
	input  wire class_t hit,
	output logic        slot_free,
	apsc_res_if.source  result
);

	count_t ti_q, tv_q, mt_q, ms_q, col_q;
	count_t ti_nx, tv_nx, mt_nx, ms_nx, col_nx;
	logic   res_valid_q;
	field_t res_ti_q, res_tv_q, res_mt_q, res_ms_q, res_col_q;

	always_comb begin
		ti_nx  = sat_bump(ti_q, hit.transition);
		tv_nx  = sat_bump(tv_q, hit.transversion);
		mt_nx  = sat_bump(mt_q, hit.match);
		ms_nx  = sat_bump(ms_q, hit.missing);
		col_nx = sat_bump(col_q, 1'b1);
	end

	assign slot_free = !res_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ti_q  <= '0;
			tv_q  <= '0;
			mt_q  <= '0;
			ms_q  <= '0;
			col_q <= '0;
		end else if (take) begin
			if (last_column) begin
				ti_q  <= '0;
				tv_q  <= '0;
				mt_q  <= '0;
				ms_q  <= '0;
				col_q <= '0;
			end else begin
				ti_q  <= ti_nx;
				tv_q  <= tv_nx;
				mt_q  <= mt_nx;
				ms_q  <= ms_nx;
				col_q <= col_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take && last_column) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// result payload, counts truncated to the field width
	always_ff @(posedge clk) begin
		if (take && last_column) begin
			res_ti_q  <= FIELD_BITS'(ti_nx);
			res_tv_q  <= FIELD_BITS'(tv_nx);
			res_mt_q  <= FIELD_BITS'(mt_nx);
			res_ms_q  <= FIELD_BITS'(ms_nx);
			res_col_q <= FIELD_BITS'(col_nx);
		end
	end

	assign result.valid              = res_valid_q;
	assign result.transition_count   = res_ti_q;
	assign result.transversion_count = res_tv_q;
	assign result.match_count        = res_mt_q;
	assign result.missing_count      = res_ms_q;
	assign result.column_total       = res_col_q;

endmodule

`default_nettype wire

### rtl/core/aligned_pair_substitution_counter_unit.sv
// path: an accepted column word is held in the input stage, then added to the counters when taken;
// its result word, if last, is registered into the result slot as that column is taken
// throughput: one column word per cycle, set by the single counter update stage
// a pending result only holds the input while the next last column waits
// reset: arst_n clears the input stage valid, all counters and the result valid
// ---------------------------------------------------------------------------
// aligned_pair_substitution_counter_unit
// counts transitions, transversions, matches and shared missing columns
// ---------------------------------------------------------------------------
`default_nettype none

module aligned_pair_substitution_counter_unit import apsc_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	apsc_col_if.sink   column,
	apsc_res_if.source result
);

	logic                 valid_s1;
	logic [BASE_BITS-1:0] first_s1;
	logic [BASE_BITS-1:0] second_s1;
	logic                 last_s1;
	logic                 slot_free;
	logic                 take;
	class_t               hit;

	// a last column needs the result slot, other columns always move on
	assign take         = valid_s1 && (!last_s1 || slot_free);
	assign column.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (column.ready) begin
			valid_s1 <= column.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (column.ready && column.valid) begin
			first_s1  <= column.base_first;
			second_s1 <= column.base_second;
			last_s1   <= column.last_column;
		end
	end

	apsc_classify u_classify (
		.base_first  (first_s1),
		.base_second (second_s1),
		.hit         (hit)
	);

	apsc_accum u_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.last_column (last_s1),
		.hit         (hit),
		.slot_free   (slot_free),
		.result      (result)
	);

endmodule

`default_nettype wire

### rtl/core/apsc_checker.sv
// ---------------------------------------------------------------------------
// apsc_checker
// port-level checks of the substitution counter, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module apsc_checker import apsc_pkg::*; (
	input wire logic   clk,
	input wire logic   arst_n,
	input wire logic   out_valid,
	input wire logic   out_ready,
	input wire field_t transition_count,
	input wire field_t match_count,
	input wire field_t column_total
);

	// a waiting result word is not dropped
	`APSC_ASSERT(a_res_hold, clk, arst_n, out_valid && !out_ready |=> out_valid)
	// every result covers at least its own last column
	`APSC_ASSERT_IMPL(a_col_nonzero, clk, arst_n, out_valid, column_total != '0)
	// transition and match counts never pass the column count
	`APSC_ASSERT_IMPL(a_ti_bound, clk, arst_n, out_valid, transition_count <= column_total)
	`APSC_ASSERT_IMPL(a_mt_bound, clk, arst_n, out_valid, match_count <= column_total)

endmodule

bind aligned_pair_substitution_counter_unit apsc_checker u_apsc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (result.valid),
	.out_ready        (result.ready),
	.transition_count (result.transition_count),
	.match_count      (result.match_count),
	.column_total     (result.column_total)
);

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aligned pair substitution counter testbench
// drives aligned columns over the column channel, predicts the per-pair
// transition, transversion, match, shared missing and column counts, and
// checks every result word against the prediction in arrival order
// ---------------------------------------------------------------------------

typedef struct packed {
	apsc_pkg::field_t transitions;
	apsc_pkg::field_t transversions;
	apsc_pkg::field_t match_hits;
	apsc_pkg::field_t missing;
	apsc_pkg::field_t columns;
} pair_tally_t;

class substitution_tally;
	apsc_pkg::count_t transitions;
	apsc_pkg::count_t transversions;
	apsc_pkg::count_t match_hits;
	apsc_pkg::count_t missing;
	apsc_pkg::count_t columns;
	pair_tally_t      owed[$];
	int               errors;

	function new();
		clear();
		errors = 0;
	endfunction

	function void clear();
		transitions   = '0;
		transversions = '0;
		match_hits    = '0;
		missing       = '0;
		columns       = '0;
	endfunction

	function int pending();
		return owed.size();
	endfunction

	static function bit purine(logic [7:0] c);
		return c == apsc_pkg::CH_A || c == apsc_pkg::CH_G;
	endfunction

	static function bit pyrimidine(logic [7:0] c);
		return c == apsc_pkg::CH_C || c == apsc_pkg::CH_T;
	endfunction

	static function apsc_pkg::count_t step_up(apsc_pkg::count_t v);
		return (v == apsc_pkg::COUNT_MAX) ? v : v + 1'b1;
	endfunction

	// one accepted column word
	function void note_column(logic [7:0] first, logic [7:0] second, logic is_last);
		bit          first_nuc;
		bit          second_nuc;
		pair_tally_t t;
		first_nuc  = purine(first) || pyrimidine(first);
		second_nuc = purine(second) || pyrimidine(second);
		if (first_nuc && second_nuc) begin
			if (first == second)
				match_hits = step_up(match_hits);
			else if (purine(first) == purine(second))
				transitions = step_up(transitions);
			else
				transversions = step_up(transversions);
		end else if (first == second && (first == apsc_pkg::CH_N || first == apsc_pkg::CH_GAP)) begin
			missing = step_up(missing);
		end
		columns = step_up(columns);
		if (is_last) begin
			t.transitions   = apsc_pkg::field_t'(transitions);
			t.transversions = apsc_pkg::field_t'(transversions);
			t.match_hits    = apsc_pkg::field_t'(match_hits);
			t.missing       = apsc_pkg::field_t'(missing);
			t.columns       = apsc_pkg::field_t'(columns);
			owed = {owed, t};
			clear();
		end
	endfunction

	function void compare(string name, apsc_pkg::field_t want, apsc_pkg::field_t got);
		if (want !== got) begin
			$error("%s expected %0d actual %0d", name, want, got);
			errors++;
		end
	endfunction

	function void check_result(pair_tally_t got);
		pair_tally_t want;
		if (owed.size() == 0) begin
			$error("result word with nothing expected");
			errors++;
			return;
		end
		want = owed.pop_front();
		compare("transition_count", want.transitions, got.transitions);
		compare("transversion_count", want.transversions, got.transversions);
		compare("match_count", want.match_hits, got.match_hits);
		compare("missing_count", want.missing, got.missing);
		compare("column_total", want.columns, got.columns);
	endfunction
endclass

module tb;
	import apsc_pkg::*;

	localparam int CYCLE_LIMIT  = 2000000;
	localparam int HOLD_CYCLES  = 500;
	localparam int RANDOM_WORDS = 1850;

	logic clk;
	logic arst_n;

	apsc_col_if col_ch ();
	apsc_res_if res_ch ();

	aligned_pair_substitution_counter_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.column (col_ch),
		.result (res_ch)
	);

	substitution_tally tally = new();

	bit idle_on       = 1'b1;
	bit hold_request  = 1'b0;
	int burst_left    = 0;
	int words_sent    = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		arst_n             <= 1'b0;
		col_ch.valid       <= 1'b0;
		col_ch.base_first  <= '0;
		col_ch.base_second <= '0;
		col_ch.last_column <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("[aligned_pair_substitution_counter_unit] ERROR");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (col_ch.valid && col_ch.ready)
				tally.note_column(col_ch.base_first, col_ch.base_second, col_ch.last_column);
			if (res_ch.valid && res_ch.ready)
				tally.check_result('{res_ch.transition_count, res_ch.transversion_count,
					res_ch.match_count, res_ch.missing_count, res_ch.column_total});
		end
	end

	// receiver: stretches of steady, light or heavy stalling, plus one long hold-off
	initial begin
		int stretch_left;
		int stall_mode;
		stretch_left = 0;
		stall_mode   = 0;
		res_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (stretch_left == 0) begin
					stall_mode   = $urandom_range(0, 2);
					stretch_left = $urandom_range(10, 200);
				end
				stretch_left--;
				case (stall_mode)
					0: res_ch.ready <= 1'b1;
					1: res_ch.ready <= 1'($urandom_range(0, 1));
					default: res_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	task automatic send_column(input logic [7:0] first, input logic [7:0] second,
		input logic is_last);
		if (idle_on && burst_left == 0) begin
			col_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		col_ch.valid       <= 1'b1;
		col_ch.base_first  <= first;
		col_ch.base_second <= second;
		col_ch.last_column <= is_last;
		do @(posedge clk); while (!col_ch.ready);
		if (burst_left > 0)
			burst_left--;
		words_sent++;
	endtask

	// sender pause until every result word is back
	task automatic drain();
		col_ch.valid <= 1'b0;
		do @(posedge clk); while (tally.pending() != 0);
	endtask

	function automatic logic [7:0] pick_base();
		case ($urandom_range(0, 9))
			0, 1: return CH_A;
			2: return CH_C;
			3: return CH_G;
			4: return CH_T;
			5: return CH_N;
			6: return CH_GAP;
			7: begin
				case ($urandom_range(0, 3))
					0: return CH_C;
					1: return CH_T;
					2: return CH_G;
					default: return CH_A;
				endcase
			end
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_pair(input int len);
		logic [7:0] first;
		logic [7:0] second;
		for (int i = 0; i < len; i++) begin
			first  = pick_base();
			second = ($urandom_range(0, 9) < 3) ? first : pick_base();
			send_column(first, second, i == len - 1);
		end
	endtask

	initial begin
		bit held;
		bit paused;
		held   = 1'b0;
		paused = 1'b0;
		@(posedge arst_n);
		@(posedge clk);

		// every class of column in one pair, then odd characters and two lone columns
		send_column(CH_A, CH_A, 1'b0);
		send_column(CH_C, CH_C, 1'b0);
		send_column(CH_G, CH_G, 1'b0);
		send_column(CH_T, CH_T, 1'b0);
		send_column(CH_A, CH_G, 1'b0);
		send_column(CH_G, CH_A, 1'b0);
		send_column(CH_C, CH_T, 1'b0);
		send_column(CH_T, CH_C, 1'b0);
		send_column(CH_A, CH_C, 1'b0);
		send_column(CH_A, CH_T, 1'b0);
		send_column(CH_G, CH_C, 1'b0);
		send_column(CH_T, CH_G, 1'b0);
		send_column(CH_N, CH_N, 1'b0);
		send_column(CH_GAP, CH_GAP, 1'b0);
		send_column(CH_N, CH_GAP, 1'b0);
		send_column(CH_GAP, CH_N, 1'b1);
		send_column(8'h61, 8'h61, 1'b0);
		send_column(CH_A, CH_N, 1'b0);
		send_column(8'h00, 8'hFF, 1'b0);
		send_column(8'hFF, 8'hFF, 1'b1);
		send_column(CH_C, CH_A, 1'b1);
		send_column(8'h00, 8'h00, 1'b1);
		drain();

		words_sent = 0;
		while (words_sent < RANDOM_WORDS) begin
			if (!held && words_sent > 600) begin
				// long receiver hold-off while short pairs keep coming
				held = 1'b1;
				hold_request = 1'b1;
				for (int i = 0; i < 30; i++)
					send_pair($urandom_range(1, 2));
			end else if (!paused && words_sent > 1200) begin
				paused = 1'b1;
				drain();
			end else if ($urandom_range(0, 9) == 0) begin
				send_pair($urandom_range(31, 300));
			end else begin
				send_pair($urandom_range(1, 30));
			end
		end
		col_ch.valid <= 1'b0;

		while (tally.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (tally.errors == 0)
			$display("[aligned_pair_substitution_counter_unit] OK");
		else
			$display("[aligned_pair_substitution_counter_unit] ERROR");
		$finish;
	end
endmodule
